>>> hdl/tlst_pkg.sv
// Package for the two-level slot table: geometry constants, field widths,
// operation and register codes, and the block-level priority encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlst_pkg;

    localparam int BLOCK_SIZE   = 16;
    localparam int NUM_BLOCKS   = 16;
    localparam int HANDLE_WIDTH = 32;

    localparam int TOTAL_SLOTS = NUM_BLOCKS * BLOCK_SIZE;
    localparam int OFS_W       = $clog2(BLOCK_SIZE);
    localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SCAN_W      = BLK_W + 1;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);

    localparam int OP_W        = 3;
    localparam int INDEX_W     = 8;
    localparam int FIELD_H_W   = 32;
    localparam int BIU_W       = 5;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - FIELD_H_W - 1 - INDEX_W;

    localparam logic [OP_W-1:0] OP_GET      = 3'd0;
    localparam logic [OP_W-1:0] OP_FIRST    = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_FREE = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD_AT   = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd5;
    localparam logic [OP_W-1:0] OP_ANY      = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_MODE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 4'd1;

    typedef logic [HANDLE_WIDTH-1:0] handle_t;
    typedef logic [BLOCK_SIZE-1:0] blk_occ_t;
    typedef blk_occ_t [NUM_BLOCKS-1:0] occ_t;

    function automatic logic [OFS_W-1:0] lowest_set(input blk_occ_t v);
        logic [OFS_W-1:0] pos;
        pos = '0;
        for (int i = BLOCK_SIZE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = OFS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> hdl/two_level_slot_table_top.sv
// Two-level slot table: handle store in a memory with one read port and one write port,
// per-slot occupied flags. Outside single mode, first, next, add-free and any walk up to
// min(blocks_in_use, 16) blocks, one block per cycle, through the shared 16-bit priority
// encoder. One request is worked at a time; a new one is accepted in the cycle after the
// result is loaded, and the load waits while an earlier result is still unaccepted.
// Reset clears every occupied flag at once; there is no clearing pass. Uses tlst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module two_level_slot_table_top
    import tlst_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // operation[2:0], index[10:3], handle[42:11], zero padding[47:43]
    input  wire  [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // found_handle[31:0], ok[32], slot_index[40:33], zero padding[47:41]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    handle_t              handle_reg, handle_next;
    occ_t                 occ_reg, occ_next;
    logic                 cfg_single_reg, cfg_single_next;
    logic [BIU_W-1:0]     cfg_biu_reg, cfg_biu_next;
    logic [SCAN_W-1:0]    blk_reg, blk_next;
    logic [OFS_W-1:0]     ofs_reg, ofs_next;
    logic [FIELD_H_W-1:0] res_found_reg, res_found_next;
    logic                 res_ok_reg, res_ok_next;
    logic [INDEX_W-1:0]   res_where_reg, res_where_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    handle_t              mem [TOTAL_SLOTS];
    handle_t              mem_q;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;

    logic [OP_W-1:0]      s_op;
    logic [INDEX_W-1:0]   s_idx;
    logic [FIELD_H_W-1:0] s_handle;

    logic [SCAN_W-1:0]    nb;
    logic                 in_range;
    logic [BLK_W-1:0]     idx_blk;
    logic [OFS_W-1:0]     idx_ofs;
    logic [SLOT_W-1:0]    idx_addr;
    logic [31:0]          next_start;
    blk_occ_t             cur_occ;
    blk_occ_t             cand;
    logic [OFS_W-1:0]     hit_ofs;
    logic [31:0]          hit_pos;
    logic                 out_load;
    logic [TOTAL_SLOTS-1:0] occ_flat;

    assign s_op     = s_tdata[2:0];
    assign s_idx    = s_tdata[10:3];
    assign s_handle = s_tdata[42:11];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        if (32'(cfg_biu_reg) > NUM_BLOCKS)
        begin
            nb = SCAN_W'(NUM_BLOCKS);
        end
        else
        begin
            nb = SCAN_W'(cfg_biu_reg);
        end
    end

    assign in_range   = 32'(idx_reg) < 32'(nb) * BLOCK_SIZE;
    assign idx_blk    = BLK_W'(32'(idx_reg) / BLOCK_SIZE);
    assign idx_ofs    = OFS_W'(32'(idx_reg) % BLOCK_SIZE);
    assign idx_addr   = SLOT_W'(idx_reg);
    assign next_start = 32'(idx_reg) + 32'd1;

    assign cur_occ = occ_reg[blk_reg[BLK_W-1:0]];
    assign cand    = ((op_reg == OP_ADD_FREE) ? ~cur_occ : cur_occ)
                     & ({BLOCK_SIZE{1'b1}} << ofs_reg);
    assign hit_ofs = lowest_set(cand);
    assign hit_pos = 32'(blk_reg) * BLOCK_SIZE + 32'(hit_ofs);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        handle_next     = handle_reg;
        occ_next        = occ_reg;
        blk_next        = blk_reg;
        ofs_next        = ofs_reg;
        res_found_next  = res_found_reg;
        res_ok_next     = res_ok_reg;
        res_where_next  = res_where_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_op;
                    idx_next    = s_idx;
                    handle_next = HANDLE_WIDTH'(s_handle);
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                res_found_next = '0;
                res_ok_next    = 1'b0;
                res_where_next = '0;
                state_next     = ST_DONE;
                if (cfg_single_reg)
                begin
                    unique case (op_reg) inside
                        OP_GET, OP_FIRST:
                        begin
                            rd_en       = 1'b1;
                            res_ok_next = occ_reg[0][0];
                            state_next  = ST_READ;
                        end
                        OP_ADD_FREE, OP_ADD_AT:
                        begin
                            if (handle_reg != '0 && !occ_reg[0][0])
                            begin
                                wr_en          = 1'b1;
                                occ_next[0][0] = 1'b1;
                                res_ok_next    = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            occ_next[0][0] = 1'b0;
                            res_ok_next    = 1'b1;
                        end
                        OP_ANY:
                        begin
                            res_ok_next = occ_reg[0][0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    unique case (op_reg) inside
                        OP_GET:
                        begin
                            if (in_range)
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = idx_addr;
                                res_ok_next    = occ_reg[idx_blk][idx_ofs];
                                res_where_next = occ_reg[idx_blk][idx_ofs] ? idx_reg : '0;
                                state_next     = ST_READ;
                            end
                        end
                        OP_FIRST, OP_ANY:
                        begin
                            blk_next   = '0;
                            ofs_next   = '0;
                            state_next = ST_SCAN;
                        end
                        OP_NEXT:
                        begin
                            if (in_range)
                            begin
                                blk_next   = SCAN_W'(next_start / BLOCK_SIZE);
                                ofs_next   = OFS_W'(next_start % BLOCK_SIZE);
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ADD_FREE:
                        begin
                            if (handle_reg != '0)
                            begin
                                blk_next   = '0;
                                ofs_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ADD_AT:
                        begin
                            if (handle_reg != '0 && in_range)
                            begin
                                wr_en                      = 1'b1;
                                wr_addr                    = idx_addr;
                                occ_next[idx_blk][idx_ofs] = 1'b1;
                                res_ok_next                = 1'b1;
                                res_where_next             = idx_reg;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_range && (|occ_reg[idx_blk]))
                            begin
                                occ_next[idx_blk][idx_ofs] = 1'b0;
                                res_ok_next                = 1'b1;
                                res_where_next             = idx_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (blk_reg >= nb)
                begin
                    state_next = ST_DONE;
                end
                else if (|cand)
                begin
                    res_ok_next    = 1'b1;
                    res_where_next = INDEX_W'(hit_pos);
                    state_next     = ST_DONE;
                    case (op_reg) inside
                        OP_FIRST, OP_NEXT:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = SLOT_W'(hit_pos);
                            state_next = ST_READ;
                        end
                        OP_ADD_FREE:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = SLOT_W'(hit_pos);
                            occ_next[blk_reg[BLK_W-1:0]][hit_ofs] = 1'b1;
                        end
                        OP_ANY:
                        begin
                            res_where_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    blk_next = blk_reg + SCAN_W'(1);
                    ofs_next = '0;
                end
            end
            ST_READ:
            begin
                res_found_next = res_ok_reg ? FIELD_H_W'(mem_q) : '0;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_data_next   = {{M_PAD_W{1'b0}}, res_where_reg, res_ok_reg, res_found_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb
    begin
        cfg_single_next = cfg_single_reg;
        cfg_biu_next    = cfg_biu_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SINGLE_MODE:   cfg_single_next = cfg_data[0];
                CFG_BLOCKS_IN_USE: cfg_biu_next    = cfg_data[BIU_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            cfg_single_reg <= 1'b0;
            cfg_biu_reg    <= BIU_W'(16);
            blk_reg        <= '0;
            ofs_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            cfg_single_reg <= cfg_single_next;
            cfg_biu_reg    <= cfg_biu_next;
            blk_reg        <= blk_next;
            ofs_reg        <= ofs_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        handle_reg    <= handle_next;
        res_found_reg <= res_found_next;
        res_ok_reg    <= res_ok_next;
        res_where_reg <= res_where_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= handle_reg;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign occ_flat = occ_reg;

    // A scan advances exactly one block per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN)
        |-> (blk_reg == $past(blk_reg) + SCAN_W'(1)))
        else $error("slot scan skipped or repeated a block");

    // Read data is only consumed in the cycle after a memory read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(rd_en))
        else $error("handle consumed without a memory read");

    // In single mode no slot other than slot zero changes occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_single_reg) |-> $stable(occ_flat >> 1))
        else $error("single mode touched a slot other than slot zero");

endmodule

`default_nettype wire
